// File: hw/rtl/fspf_pkg.sv
// ----------------------------------------------------------------------------
// fspf_pkg: shared types and constants for the substring position finder
// Holds the size limits, the item and result structures and the function code.
// ----------------------------------------------------------------------------
package fspf_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int TEXT_MAX    = 65535;

    localparam int CH_W  = 8;
    localparam int POS_W = 16;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W = $clog2(TEXT_MAX + 1);
    // Common width for length/count arithmetic; covers both counters.
    localparam int CMP_W = POS_W + 1;

    typedef enum logic {
        FUNC_PATTERN = 1'b0,
        FUNC_TEXT    = 1'b1
    } t_func;

    typedef struct packed {
        t_func           func;
        logic [CH_W-1:0] ch;
        logic            last;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
        logic             overflow;
    } t_result;

endpackage

// File: hw/rtl/fspf_matcher.sv
// ----------------------------------------------------------------------------
// fspf_matcher: pattern store, text window and combinational window compare
// Applies one beat per enabled cycle and presents the result it would emit.
// ----------------------------------------------------------------------------
module fspf_matcher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step_en,
    input  fspf_pkg::t_item  i_item,
    output logic             o_emit,
    output fspf_pkg::t_result o_result
);
    import fspf_pkg::*;

    // The pattern is kept reversed: entry 0 is the most recent pattern byte,
    // so it lines up with the text window, whose entry 0 is the newest byte.
    logic [CH_W-1:0]  r_pat_rev [PATTERN_MAX];
    logic [CH_W-1:0]  n_pat_rev [PATTERN_MAX];
    logic [CH_W-1:0]  r_win     [PATTERN_MAX];
    logic [CH_W-1:0]  n_win     [PATTERN_MAX];
    logic [LEN_W-1:0] r_pat_len, n_pat_len;
    logic             r_pat_done, n_pat_done;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_first, n_first;
    logic             r_ovf, n_ovf;

    logic [CH_W-1:0]  w_win_shift [PATTERN_MAX];
    logic [CNT_W-1:0] w_count_inc;
    logic             w_text_ok;
    logic             w_hit;
    logic [CMP_W-1:0] w_first_calc;
    logic [POS_W-1:0] w_first_upd;
    logic             w_ovf_upd;
    logic [LEN_W-1:0] w_base_len;

    always_comb begin
        w_win_shift[0] = i_item.ch;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            w_win_shift[j] = r_win[j-1];
        end
    end

    assign w_count_inc  = r_count + CNT_W'(1);
    assign w_text_ok    = (r_count < CNT_W'(TEXT_MAX));
    assign w_first_calc = CMP_W'(w_count_inc) - CMP_W'(r_pat_len) + CMP_W'(1);

    always_comb begin
        w_hit = (CMP_W'(w_count_inc) >= CMP_W'(r_pat_len));
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if ((LEN_W'(j) < r_pat_len) && (w_win_shift[j] != r_pat_rev[j])) begin
                w_hit = 1'b0;
            end
        end
    end

    assign w_first_upd = (w_text_ok && (r_first == '0) && w_hit)
                         ? w_first_calc[POS_W-1:0] : r_first;
    assign w_ovf_upd   = r_ovf | ~w_text_ok;
    assign w_base_len  = r_pat_done ? '0 : r_pat_len;

    assign o_emit            = (i_item.func == FUNC_TEXT) && i_item.last;
    assign o_result.position = w_first_upd;
    assign o_result.found    = (w_first_upd != '0);
    assign o_result.overflow = w_ovf_upd;

    always_comb begin
        n_pat_rev  = r_pat_rev;
        n_win      = r_win;
        n_pat_len  = r_pat_len;
        n_pat_done = r_pat_done;
        n_count    = r_count;
        n_first    = r_first;
        n_ovf      = r_ovf;
        if (i_step_en) begin
            if (i_item.func == FUNC_TEXT) begin
                if (w_text_ok) begin
                    n_win   = w_win_shift;
                    n_count = w_count_inc;
                end
                n_first = w_first_upd;
                n_ovf   = w_ovf_upd;
                if (i_item.last) begin
                    n_count = '0;
                    n_first = '0;
                    n_ovf   = 1'b0;
                end
            end else begin
                // A pattern byte after a completed pattern starts a new one.
                if (r_pat_done) begin
                    n_count = '0;
                    n_first = '0;
                    n_ovf   = 1'b0;
                end
                if (w_base_len < LEN_W'(PATTERN_MAX)) begin
                    n_pat_rev[0] = i_item.ch;
                    for (int j = 1; j < PATTERN_MAX; j++) begin
                        n_pat_rev[j] = r_pat_rev[j-1];
                    end
                    n_pat_len = w_base_len + LEN_W'(1);
                end else begin
                    n_pat_len = w_base_len;
                    n_ovf     = 1'b1;
                end
                n_pat_done = i_item.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len  <= '0;
            r_pat_done <= 1'b0;
            r_count    <= '0;
            r_first    <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_pat_len  <= n_pat_len;
            r_pat_done <= n_pat_done;
            r_count    <= n_count;
            r_first    <= n_first;
            r_ovf      <= n_ovf;
        end
    end

    // Byte storage needs no reset: only entries below the length are compared,
    // and the count guarantees those window entries were filled by text.
    always_ff @(posedge i_clk) begin
        r_pat_rev <= n_pat_rev;
        r_win     <= n_win;
    end

endmodule

// File: hw/rtl/first_substring_position_finder.sv
// ----------------------------------------------------------------------------
// first_substring_position_finder: first match position of a pattern in text
// Input register, combinational window compare, and a result output register.
// ----------------------------------------------------------------------------
// Order: a held beat is applied when the matcher steps; a last text beat loads
//   its result into the output register on that edge. Throughput: one beat per
//   cycle, set by the 16-byte parallel window compare, while no result stalls.
// Reset: synchronous, active low; clears the pattern length, text count, match
//   and overflow state and both stage valids. Byte storage is not cleared.
// ----------------------------------------------------------------------------
module first_substring_position_finder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [0:0]                     i_func,
    input  logic [fspf_pkg::CH_W-1:0]      i_ch,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [fspf_pkg::POS_W-1:0]     o_position,
    output logic                           o_found,
    output logic                           o_overflow
);
    import fspf_pkg::*;

    // Input stage: holds one accepted beat until the matcher applies it.
    logic    r_in_valid;
    t_item   r_in;

    // Output stage: holds one result beat until the consumer takes it.
    logic    r_out_valid;
    t_result r_out;

    logic    w_emit;
    logic    w_adv;
    t_result w_result;

    // The held beat moves on unless it makes a result and the output register
    // is still occupied by a result that is not being taken this cycle.
    assign w_adv   = r_in_valid && (!w_emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    fspf_matcher u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (w_adv),
        .i_item    (r_in),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.func <= t_func'(i_func);
            r_in.ch   <= i_ch;
            r_in.last <= i_last;
        end
        if (w_adv && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_out.position;
    assign o_found    = r_out.found;
    assign o_overflow = r_out.overflow;

    // A held input beat that cannot move on must never be overwritten.
    a_no_input_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && !w_adv && o_ready))
        else $error("input beat overwritten while stalled");

    // A stalled input beat is still there on the next cycle.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("stalled input beat lost");

    // Found flag agrees with a nonzero position on every result beat.
    a_found_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found == (o_position != '0)))
        else $error("found flag disagrees with position");

    // A new result is loaded only when the previous one is gone or leaving.
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |-> (!r_out_valid || i_ready))
        else $error("result beat overwritten");

endmodule

// File: tb/tb_first_substring_position_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_substring_position_finder: self-checking bench for the finder
// Loads patterns and streams texts over the valid/ready input channel and
// checks every result beat against a cycle-free model of the search held
// in the bench or against a typed row's value. Directed rows come first,
// then randomized pattern/text sequences with idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_first_substring_position_finder;

    import fspf_pkg::*;

    // Generous bound: even the longest legal run stays far below this.
    localparam int unsigned CYCLE_LIMIT   = 4000000;
    localparam int unsigned RANDOM_BEATS  = 1200;
    localparam int unsigned QUIET_BEATS   = 200;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PLAN_ROWS     = 23;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [0:0]         i_func;
    logic [CH_W-1:0]    i_ch;
    logic               i_last;
    logic               o_valid;
    logic               i_ready;
    logic [POS_W-1:0]   o_position;
    logic               o_found;
    logic               o_overflow;

    first_substring_position_finder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_ch       (i_ch),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_position (o_position),
        .o_found    (o_found),
        .o_overflow (o_overflow)
    );

    // ------------------------------------------------------------------
    // Search model. It mirrors the block's state: the stored pattern, the
    // sliding window of recent text bytes (index 0 is the newest byte),
    // the text byte count, the first match position and the overflow flag.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  pat_bytes [PATTERN_MAX];
    logic [LEN_W-1:0] pat_len;
    logic             pat_done;
    logic [CH_W-1:0]  recent [PATTERN_MAX];
    logic [CNT_W-1:0] txt_cnt;
    logic [CMP_W-1:0] match_pos;
    logic             ovf_flag;

    t_result          pending_results [$];
    bit               failed;
    int unsigned      beats_sent;
    int unsigned      idle_pct;
    int unsigned      stall_pct;

    function automatic void clear_search();
        int k;
        for (k = 0; k < PATTERN_MAX; k++) begin
            recent[k] = '0;
        end
        txt_cnt   = '0;
        match_pos = '0;
        ovf_flag  = 1'b0;
    endfunction

    // Applies one beat to the model. Returns 1 when the beat yields a
    // result, which is then written to res.
    function automatic bit search_step(input t_func f, input logic [CH_W-1:0] c,
                                       input logic l, output t_result res);
        int  k;
        bit  hit;
        res = '0;
        if (f == FUNC_PATTERN) begin
            // A pattern byte after a finished pattern starts a fresh one.
            if (pat_done) begin
                pat_done = 1'b0;
                pat_len  = '0;
                clear_search();
            end
            if (pat_len < PATTERN_MAX) begin
                pat_bytes[pat_len[$clog2(PATTERN_MAX)-1:0]] = c;
                pat_len = pat_len + 1'b1;
            end else begin
                ovf_flag = 1'b1;
            end
            if (l) begin
                pat_done = 1'b1;
            end
            return 1'b0;
        end
        if (txt_cnt < TEXT_MAX) begin
            for (k = PATTERN_MAX - 1; k > 0; k--) begin
                recent[k] = recent[k-1];
            end
            recent[0] = c;
            txt_cnt = txt_cnt + 1'b1;
            if (match_pos == 0 && txt_cnt >= pat_len) begin
                hit = 1'b1;
                for (k = 0; k < pat_len; k++) begin
                    if (pat_bytes[k] != recent[pat_len - 1 - k]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    match_pos = txt_cnt - pat_len + 1'b1;
                end
            end
        end else begin
            // Text past the size limit is not searched, only flagged.
            ovf_flag = 1'b1;
        end
        if (!l) begin
            return 1'b0;
        end
        res.position = match_pos[POS_W-1:0];
        res.found    = (match_pos != 0);
        res.overflow = ovf_flag;
        clear_search();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock and the timeout watchdog.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[first_substring_position_finder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts on i_ready, and the checker. Both
    // sample at the rising edge, so they see the values from before it.
    // ------------------------------------------------------------------
    initial begin
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: position %0d found %0b overflow %0b",
                         $time, o_position, o_found, o_overflow);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_position !== want.position) begin
                    $display("%0t: position mismatch: expected %0d, actual %0d",
                             $time, want.position, o_position);
                    failed = 1'b1;
                end
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, want.found, o_found);
                    failed = 1'b1;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow mismatch: expected %0b, actual %0b",
                             $time, want.overflow, o_overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side. One call sends one beat: an optional idle burst, then the
    // payload held with valid high until the block takes it. The model is
    // stepped at the accepting edge. A typed row replaces the model's
    // result with the value written into the table.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_func f, input logic [CH_W-1:0] c, input logic l,
                             input bit typed, input t_result want);
        t_result res;
        bit      has_res;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_ch    <= c;
        i_last  <= l;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        has_res = search_step(f, c, l, res);
        if (has_res) begin
            pending_results.push_back(typed ? want : res);
        end
        beats_sent++;
    endtask

    // Directed rows. A row repeats its byte reps times, and last applies
    // to the final repetition only. Rows marked typed carry the result
    // that can be read straight off the sequence.
    typedef struct {
        t_func           func;
        logic [CH_W-1:0] ch;
        logic            last;
        int unsigned     reps;
        bit              typed;
        t_result         want;
    } t_plan_row;

    localparam t_result RES_FROM_MODEL = '0;

    t_plan_row plan [PLAN_ROWS] = '{
        // Text right after reset, with no pattern stored at all.
        '{FUNC_TEXT,    8'h78, 1'b1, 1,     1'b0, RES_FROM_MODEL},
        // Pattern 00 FF, then a text that holds it at position 2.
        '{FUNC_PATTERN, 8'h00, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_PATTERN, 8'hFF, 1'b1, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'hFF, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'h00, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'hFF, 1'b1, 1,     1'b1, '{16'd2, 1'b1, 1'b0}},
        // Text shorter than the pattern: no match.
        '{FUNC_TEXT,    8'h12, 1'b1, 1,     1'b1, '{16'd0, 1'b0, 1'b0}},
        // Pattern one byte too long: the extra byte is dropped and flagged,
        // and the flag is reported with the first text only.
        '{FUNC_PATTERN, 8'h41, 1'b1, 17,    1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'h41, 1'b1, 16,    1'b1, '{16'd1, 1'b1, 1'b1}},
        '{FUNC_TEXT,    8'h41, 1'b1, 16,    1'b1, '{16'd1, 1'b1, 1'b0}},
        // Pattern bytes interleaved with text before the pattern is done.
        '{FUNC_PATTERN, 8'h55, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'h55, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_PATTERN, 8'h66, 1'b1, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'h66, 1'b1, 1,     1'b0, RES_FROM_MODEL},
        // A long text with the match well past the start of the text.
        '{FUNC_PATTERN, 8'hAB, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_PATTERN, 8'hCD, 1'b1, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'h00, 1'b0, 200,   1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'hAB, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'hCD, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'h00, 1'b1, 40,    1'b1, '{16'd201, 1'b1, 1'b0}},
        // A new pattern arriving mid-text discards the partial text.
        '{FUNC_TEXT,    8'hAB, 1'b0, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_PATTERN, 8'h11, 1'b1, 1,     1'b0, RES_FROM_MODEL},
        '{FUNC_TEXT,    8'h11, 1'b1, 1,     1'b1, '{16'd1, 1'b1, 1'b0}}
    };

    // Random part. Most sequences are a fresh pattern followed by a few
    // texts over a narrow alphabet, often with the pattern planted inside,
    // so that matches are common. The rest are stray beats of any kind.
    task automatic run_random();
        logic [CH_W-1:0] pat [$];
        logic [CH_W-1:0] txt [$];
        logic [CH_W-1:0] base;
        int unsigned     span;
        int unsigned     plen;
        int unsigned     tlen;
        int unsigned     spot;
        int unsigned     n;
        int unsigned     j;
        int unsigned     t;
        int unsigned     start;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            if (beats_sent - start >= RANDOM_BEATS - QUIET_BEATS) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
                case ($urandom_range(2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            base = CH_W'($urandom_range(255));
            n = $urandom_range(9);
            span = (n < 5) ? 2 : (n < 8) ? 4 : 256;
            if ($urandom_range(99) < 70) begin
                n = $urandom_range(99);
                plen = (n < 85) ? $urandom_range(4, 1) :
                       (n < 95) ? $urandom_range(16, 5) : $urandom_range(20, 17);
                pat.delete();
                for (j = 0; j < plen; j++) begin
                    pat.push_back(CH_W'(base + $urandom_range(span - 1)));
                    send_beat(FUNC_PATTERN, pat[j], j == plen - 1, 1'b0, RES_FROM_MODEL);
                end
                for (t = $urandom_range(3, 1); t > 0; t--) begin
                    tlen = $urandom_range(24, 1);
                    txt.delete();
                    for (j = 0; j < tlen; j++) begin
                        txt.push_back(CH_W'(base + $urandom_range(span - 1)));
                    end
                    if ($urandom_range(1) == 1 && tlen >= plen) begin
                        spot = $urandom_range(tlen - plen);
                        for (j = 0; j < plen; j++) begin
                            txt[spot + j] = pat[j];
                        end
                    end
                    for (j = 0; j < tlen; j++) begin
                        send_beat(FUNC_TEXT, txt[j], j == tlen - 1, 1'b0, RES_FROM_MODEL);
                    end
                end
            end else begin
                for (n = $urandom_range(6, 1); n > 0; n--) begin
                    send_beat($urandom_range(1) ? FUNC_TEXT : FUNC_PATTERN,
                              CH_W'($urandom_range(255)), $urandom_range(3) == 0,
                              1'b0, RES_FROM_MODEL);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned k;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_func     <= FUNC_PATTERN;
        i_ch       <= '0;
        i_last     <= 1'b0;
        failed     = 1'b0;
        beats_sent = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        // The model starts from the block's reset state; unwritten pattern
        // bytes are never read, so zero is as good as any value there.
        for (k = 0; k < PATTERN_MAX; k++) begin
            pat_bytes[k] = '0;
        end
        pat_len  = '0;
        pat_done = 1'b0;
        clear_search();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct  = 20;
        stall_pct = 20;
        for (r = 0; r < PLAN_ROWS; r++) begin
            for (k = 1; k <= plan[r].reps; k++) begin
                send_beat(plan[r].func, plan[r].ch,
                          plan[r].last && (k == plan[r].reps),
                          plan[r].typed && (k == plan[r].reps), plan[r].want);
            end
        end

        run_random();
        i_valid <= 1'b0;

        // Drain, then keep watching the result side so that a stray
        // extra result beat would still be caught.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!failed) begin
            $display("[first_substring_position_finder] OK");
        end else begin
            $display("[first_substring_position_finder] ERROR");
        end
        $finish;
    end

endmodule
